@@ sv/midi_tsp_pkg.sv @@
// Package for the MIDI track stream parser: parser phases, result kinds,
// protocol byte constants and the result bundle passed from core to output buffer.
// No dependencies.
package midi_tsp_pkg;

    // Parser phase, one-hot
    typedef enum logic [8:0] {
        PH_DELTA    = 9'b000000001,
        PH_STATUS   = 9'b000000010,
        PH_DATA1    = 9'b000000100,
        PH_DATA2    = 9'b000001000,
        PH_SYSLEN   = 9'b000010000,
        PH_SYSDATA  = 9'b000100000,
        PH_METATYPE = 9'b001000000,
        PH_METALEN  = 9'b010000000,
        PH_METADATA = 9'b100000000
    } phase_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_TEMPO = 2'd1,
        KIND_EOT   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    localparam int unsigned VALUE_W = 24;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned VLQ_W   = 28;

    localparam logic [3:0] CLASS_SYSTEM   = 4'hF;
    localparam logic [3:0] CLASS_PROGRAM  = 4'hC;
    localparam logic [3:0] CLASS_CHPRESS  = 4'hD;
    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [2:0] VLQ_MAX_BYTES  = 3'd4;
    localparam logic [2:0] TEMPO_BYTES    = 3'd3;

    // One result item without its tick
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } res_t;

    // All results caused by one input byte; they share one tick
    typedef struct packed {
        logic [1:0]        count;
        logic [TICK_W-1:0] tick;
        res_t [2:0]        res;
    } bundle_t;

    // Output buffer status toward the core
    typedef struct packed {
        logic can_load;
    } obuf_stat_t;

endpackage

@@ sv/midi_tsp_core.sv @@
// Parser core: track state registers and the single-pass decode of one byte
// into the next state and a bundle of up to three results.
// Depends on midi_tsp_pkg.
module midi_tsp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  logic                 track_first,
    input  logic                 track_final,
    input  logic                 seq_tracks,
    output midi_tsp_pkg::bundle_t bundle
);
    import midi_tsp_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic [TICK_W-1:0]  tick_reg,     tick_next;
    logic [VLQ_W-1:0]   dacc_reg,     dacc_next;
    logic [2:0]         lbc_reg,      lbc_next;
    logic [7:0]         rs_reg,       rs_next;
    logic [7:0]         cs_reg,       cs_next;
    logic [7:0]         mk_reg,       mk_next;
    logic [VLQ_W-1:0]   br_reg,       br_next;
    logic [VALUE_W-1:0] tacc_reg,     tacc_next;
    logic               halted_reg,   halted_next;

    logic [VLQ_W-1:0]   vacc;
    logic [VLQ_W-1:0]   br_dec;
    logic [2:0]         lbc_inc;
    logic [1:0]         n;
    logic               fresh;
    logic [7:0]         stat;

    // Decode one byte
    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        dacc_next   = dacc_reg;
        lbc_next    = lbc_reg;
        rs_next     = rs_reg;
        cs_next     = cs_reg;
        mk_next     = mk_reg;
        br_next     = br_reg;
        tacc_next   = tacc_reg;
        halted_next = halted_reg;
        n           = 2'd0;
        bundle      = '0;
        vacc        = '0;
        br_dec      = '0;
        lbc_inc     = '0;
        fresh       = data_byte[7];
        stat        = '0;

        // Restart on the first byte of a chunk
        if (track_first) begin
            if (!seq_tracks) begin
                tick_next = '0;
            end
            phase_next  = PH_DELTA;
            dacc_next   = '0;
            lbc_next    = '0;
            rs_next     = '0;
            cs_next     = '0;
            mk_next     = '0;
            br_next     = '0;
            tacc_next   = '0;
            halted_next = 1'b0;
        end

        if (!halted_next) begin
            lbc_inc = lbc_next + 3'd1;
            br_dec  = br_next - VLQ_W'(1);
            unique case (phase_next)
                PH_DELTA: begin
                    vacc      = {dacc_next[VLQ_W-8:0], data_byte[6:0]};
                    dacc_next = vacc;
                    lbc_next  = lbc_inc;
                    if (!data_byte[7]) begin
                        tick_next  = tick_next + TICK_W'(vacc);
                        dacc_next  = '0;
                        lbc_next   = '0;
                        phase_next = PH_STATUS;
                    end else if (lbc_inc >= VLQ_MAX_BYTES) begin
                        bundle.res[n] = '{kind: KIND_ERROR, value: '0};
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                PH_STATUS: begin
                    if (fresh) begin
                        rs_next = data_byte;
                    end
                    stat    = rs_next;
                    cs_next = stat;
                    if (stat[7:4] != CLASS_SYSTEM) begin
                        bundle.res[n] = '{kind: KIND_EVENT, value: VALUE_W'({stat[7:4], 4'h0})};
                        n = n + 2'd1;
                        phase_next = PH_DATA1;
                        // Running status: this byte is the first data byte
                        if (!fresh) begin
                            bundle.res[n] = '{kind: KIND_EVENT, value: VALUE_W'(data_byte)};
                            n = n + 2'd1;
                            phase_next = (stat[7:4] == CLASS_PROGRAM ||
                                          stat[7:4] == CLASS_CHPRESS) ? PH_DELTA : PH_DATA2;
                        end
                    end else if (stat != STATUS_META) begin
                        br_next    = '0;
                        lbc_next   = '0;
                        phase_next = PH_SYSLEN;
                        // Running status: this byte is a one-byte length
                        if (!fresh) begin
                            br_next    = VLQ_W'(data_byte[6:0]);
                            phase_next = (data_byte[6:0] == 7'd0) ? PH_DELTA : PH_SYSDATA;
                        end
                    end else begin
                        phase_next = PH_METATYPE;
                        // Running status: this byte is the meta type
                        if (!fresh) begin
                            mk_next    = data_byte;
                            br_next    = '0;
                            lbc_next   = '0;
                            phase_next = PH_METALEN;
                        end
                    end
                end
                PH_DATA1: begin
                    bundle.res[n] = '{kind: KIND_EVENT, value: VALUE_W'(data_byte)};
                    n = n + 2'd1;
                    phase_next = (cs_next[7:4] == CLASS_PROGRAM ||
                                  cs_next[7:4] == CLASS_CHPRESS) ? PH_DELTA : PH_DATA2;
                end
                PH_DATA2: begin
                    bundle.res[n] = '{kind: KIND_EVENT, value: VALUE_W'(data_byte)};
                    n = n + 2'd1;
                    phase_next = PH_DELTA;
                end
                PH_SYSLEN: begin
                    vacc     = {br_next[VLQ_W-8:0], data_byte[6:0]};
                    br_next  = vacc;
                    lbc_next = lbc_inc;
                    if (!data_byte[7]) begin
                        lbc_next   = '0;
                        phase_next = (vacc == '0) ? PH_DELTA : PH_SYSDATA;
                    end else if (lbc_inc >= VLQ_MAX_BYTES) begin
                        bundle.res[n] = '{kind: KIND_ERROR, value: '0};
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                PH_SYSDATA: begin
                    bundle.res[n] = '{kind: KIND_EVENT, value: VALUE_W'(data_byte)};
                    n = n + 2'd1;
                    br_next = br_dec;
                    if (br_dec == '0) begin
                        phase_next = PH_DELTA;
                    end
                end
                PH_METATYPE: begin
                    mk_next    = data_byte;
                    br_next    = '0;
                    lbc_next   = '0;
                    phase_next = PH_METALEN;
                end
                PH_METALEN: begin
                    vacc     = {br_next[VLQ_W-8:0], data_byte[6:0]};
                    br_next  = vacc;
                    lbc_next = lbc_inc;
                    if (!data_byte[7]) begin
                        lbc_next  = '0;
                        tacc_next = '0;
                        if (mk_next == META_TEMPO && vacc < VLQ_W'(TEMPO_BYTES)) begin
                            bundle.res[n] = '{kind: KIND_ERROR, value: '0};
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end else if (vacc == '0) begin
                            // Empty meta is complete at once
                            if (mk_next == META_EOT) begin
                                bundle.res[n] = '{kind: KIND_EOT, value: '0};
                                n = n + 2'd1;
                                halted_next = 1'b1;
                            end
                            phase_next = PH_DELTA;
                        end else begin
                            phase_next = PH_METADATA;
                        end
                    end else if (lbc_inc >= VLQ_MAX_BYTES) begin
                        bundle.res[n] = '{kind: KIND_ERROR, value: '0};
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                PH_METADATA: begin
                    // Collect the three tempo bytes, skip the rest
                    if (mk_next == META_TEMPO && lbc_next < TEMPO_BYTES) begin
                        tacc_next = {tacc_next[VALUE_W-9:0], data_byte};
                        lbc_next  = lbc_inc;
                        if (lbc_inc == TEMPO_BYTES && tacc_next != '0) begin
                            bundle.res[n] = '{kind: KIND_TEMPO, value: tacc_next};
                            n = n + 2'd1;
                        end
                    end
                    br_next = br_dec;
                    if (br_dec == '0) begin
                        if (mk_next == META_EOT) begin
                            bundle.res[n] = '{kind: KIND_EOT, value: '0};
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        phase_next = PH_DELTA;
                        lbc_next   = '0;
                    end
                end
                default: begin
                    phase_next = PH_DELTA;
                end
            endcase

            // Flag a chunk that ends mid-element, then halt
            if (track_final && !halted_next) begin
                if (phase_next != PH_DELTA || lbc_next != '0) begin
                    bundle.res[n] = '{kind: KIND_ERROR, value: '0};
                    n = n + 2'd1;
                end
            end
            if (track_final) begin
                halted_next = 1'b1;
            end
        end

        bundle.count = n;
        bundle.tick  = tick_next;
    end

    // Commit state when the byte is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            tick_reg   <= '0;
            dacc_reg   <= '0;
            lbc_reg    <= '0;
            rs_reg     <= '0;
            cs_reg     <= '0;
            mk_reg     <= '0;
            br_reg     <= '0;
            tacc_reg   <= '0;
            halted_reg <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            dacc_reg   <= dacc_next;
            lbc_reg    <= lbc_next;
            rs_reg     <= rs_next;
            cs_reg     <= cs_next;
            mk_reg     <= mk_next;
            br_reg     <= br_next;
            tacc_reg   <= tacc_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ sv/midi_tsp_obuf.sv @@
// Result buffer: holds the up to three results of one byte and hands them
// out one per accepted item, marking the last one.
// Depends on midi_tsp_pkg.
module midi_tsp_obuf (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  midi_tsp_pkg::bundle_t    bundle,
    output midi_tsp_pkg::obuf_stat_t stat,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [55:0]              m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);
    import midi_tsp_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] idx_inc;
    res_t       cur;
    logic       take;

    assign idx_inc       = idx_reg + 2'd1;
    assign m_tvalid      = (idx_reg != cnt_reg);
    assign take          = m_tvalid && m_tready;
    assign stat.can_load = !m_tvalid || (m_tready && idx_inc == cnt_reg);

    // Select the item under the read index
    always_comb begin
        unique case (idx_reg)
            2'd1:    cur = bundle_reg.res[1];
            2'd2:    cur = bundle_reg.res[2];
            default: cur = bundle_reg.res[0];
        endcase
    end

    assign m_tdata = {bundle_reg.tick, cur.value};
    assign m_tuser = cur.kind;
    assign m_tlast = (idx_inc == cnt_reg);

    // Reload on a new bundle, else advance on each taken item
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = bundle.count;
            idx_next = 2'd0;
        end else if (take) begin
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

endmodule

@@ sv/midi_track_stream_parser.sv @@
// MIDI track stream parser, top level: input register, parser core and
// result buffer, plus the sequential-tracks register.
// Depends on midi_tsp_pkg, midi_tsp_core and midi_tsp_obuf.
//
// Usage:
//   s_ channel takes one track-chunk byte per item; s_tuser marks the first
//   byte of a chunk (the parser restarts before it), s_tlast the last byte.
//   m_ channel gives the result items of each byte in order, m_tlast set on
//   the last result of a byte; m_tuser is the kind (event byte, tempo, end of
//   track, error), m_tdata holds value and absolute tick.
//   cfg_wr_en writes cfg_wr_data into the sequential-tracks bit; write it
//   only while no item is in flight.
// An accepted byte waits in the input register until the result buffer can
//   load; it is then decoded and its results are registered in the result
//   buffer, which presents the first of them on the m_ channel.
// Throughput: one byte per cycle while each byte gives at most one result and
//   m_tready stays high; a byte with more results holds the decoder until the
//   single result port has drained the result buffer.
// Reset (aresetn low, synchronous) clears the parser state, the buffers and
//   the register. A stall on m_tready holds the current result; the input
//   register then fills and s_tready drops until room is made.
module midi_track_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // sequential_tracks
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    input  logic        s_tuser,        // [0] track_first
    input  logic        s_tlast,        // track_final
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,        // [23:0] value, [55:24] tick
    output logic [1:0]  m_tuser,        // [1:0] kind
    output logic        m_tlast         // final_res
);
    import midi_tsp_pkg::*;

    logic       seq_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_final_reg;
    logic       fire;
    bundle_t    bundle;
    obuf_stat_t obuf_stat;

    assign fire     = in_valid_reg && obuf_stat.can_load;
    assign s_tready = !in_valid_reg || fire;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            seq_reg <= cfg_wr_data;
        end
    end

    // Input register: hold the byte until the core consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_final_reg <= s_tlast;
        end
    end

    midi_tsp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .data_byte   (in_byte_reg),
        .track_first (in_first_reg),
        .track_final (in_final_reg),
        .seq_tracks  (seq_reg),
        .bundle      (bundle)
    );

    midi_tsp_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .bundle   (bundle),
        .stat     (obuf_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A decoded byte with results shows its first result next cycle
    a_results_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && bundle.count != 2'd0 |=> m_tvalid)
        else $error("decoded results not presented");

    // A decoded byte without results leaves the output empty
    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && bundle.count == 2'd0 |=> !m_tvalid)
        else $error("result presented for a byte without results");

    // A byte waiting in the input register is kept until consumed
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg)
                                  && $stable(in_final_reg))
        else $error("pending input byte lost");

endmodule
